// ===== rtl/lps_pkg.sv =====
// Shared types and constants for the load power sequencer.
// Holds the request and result payload structs, mode codes and register defaults.
// No dependencies; compiled before every other file.
package lps_pkg;

  // Power mode codes as seen on the result channel.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_FAST = 2'd2;

  // Configuration register indexes and widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_VOLT_HOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LID_TIMEOUT    = 2'd2;

  // Register values after reset.
  localparam logic [13:0] STOP_THRESHOLD_RESET = 14'd9000;
  localparam logic [7:0]  LOW_VOLT_HOLD_RESET  = 8'd7;
  localparam logic [15:0] LID_TIMEOUT_RESET    = 16'd300;

  // One control tick.
  typedef struct packed {
    logic [31:0] now_seconds;
    logic        switch_on;
    logic        lid_covered;
    logic        adaptor_present;
    logic [13:0] sys_voltage_mv;
    logic        bat1_has_runtime;
    logic        bat2_has_runtime;
    logic [31:0] lid_cover_stamp;
    logic [31:0] lid_uncover_stamp;
  } lps_tick_t;

  // One result per tick.
  typedef struct packed {
    logic [1:0] power_mode;
    logic       main_board_enable;
    logic       aux_board_enable;
    logic       fan_enable;
    logic       low_power_latched;
  } lps_result_t;

endpackage

// ===== rtl/lps_stream_if.sv =====
// Valid/ready stream interface used for the tick and result channels.
// The payload type is a parameter; the payload structs come from lps_pkg.
interface lps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/load_power_sequencer.sv =====
// Load power sequencer top level: tick register, one-pass step logic, result register.
// Depends on lps_pkg (types, codes, defaults) and lps_stream_if (channels).
//
//   channel   direction  width  contents
//   tick      in         115    one control tick (lps_tick_t)
//   result    out        6      mode, three enables, low-power flag (lps_result_t)
//   cfg_*     in         16     register write: cfg_we, cfg_index, cfg_data
//
// A request is taken into the tick register, and once the result register is free or
// drained the step logic updates the state and loads the result register.
// A new request is accepted every cycle; the only limit is the result register, which
// holds its value while the result channel stalls and then blocks the tick register.
// Reset (rst, synchronous) puts the mode to off, clears all latches and loads the
// register defaults; no clearing pass is needed.
module load_power_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  lps_stream_if.sink                     tick,
  lps_stream_if.source                   result,
  input  logic                           cfg_we,
  input  logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lps_pkg::*;

  // Configuration registers.
  logic [13:0] stop_threshold_mv;
  logic [7:0]  low_volt_hold_s;
  logic [15:0] lid_timeout_s;

  // Sequencer state.
  logic [1:0]  mode_reg;
  logic        button_latch;
  logic        cover_latch;
  logic [31:0] low_volt_since;
  logic        low_power_latch;

  // Tick register and result register.
  logic        s1_valid;
  lps_tick_t   s1_tick;
  logic        out_valid;
  lps_result_t out_result;

  logic        s1_adv;

  // Next values of the state after one step.
  logic [1:0]  mode_next;
  logic        button_next;
  logic        cover_next;
  logic [31:0] since_next;
  logic        lowpow_next;

  // Handshake: the tick register moves on when the result register is free or drained.
  assign s1_adv        = s1_valid && (!out_valid || result.ready);
  assign tick.ready    = !s1_valid || s1_adv;
  assign result.valid  = out_valid;
  assign result.payload = out_result;

  // Configuration writes keep only each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold_mv <= STOP_THRESHOLD_RESET;
      low_volt_hold_s   <= LOW_VOLT_HOLD_RESET;
      lid_timeout_s     <= LID_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_THRESHOLD: stop_threshold_mv <= cfg_data[13:0];
        CFG_LOW_VOLT_HOLD:  low_volt_hold_s   <= cfg_data[7:0];
        CFG_LID_TIMEOUT:    lid_timeout_s     <= cfg_data;
        default: ;
      endcase
    end
  end

  // One tick: off, run and fast-boot checks in order, each seeing the mode left by
  // the previous one. At most one of run and fast boot runs the low-voltage check.
  always_comb begin
    logic        may_start;
    logic        sw;
    logic        covered;
    logic        volt_low;
    logic        lv_trip;
    logic        lid_cover_late;
    logic        lid_uncover_late;
    logic [31:0] lv_elapsed;

    sw       = s1_tick.switch_on;
    covered  = s1_tick.lid_covered;
    volt_low = s1_tick.sys_voltage_mv <= stop_threshold_mv;
    lv_elapsed = s1_tick.now_seconds - low_volt_since;
    lv_trip  = volt_low && (low_volt_since != 32'd0) &&
               (lv_elapsed >= {24'd0, low_volt_hold_s});
    lid_cover_late   = (s1_tick.now_seconds - s1_tick.lid_cover_stamp) >=
                       {16'd0, lid_timeout_s};
    lid_uncover_late = (s1_tick.now_seconds - s1_tick.lid_uncover_stamp) >=
                       {16'd0, lid_timeout_s};

    mode_next   = mode_reg;
    button_next = button_latch;
    cover_next  = cover_latch;
    since_next  = low_volt_since;
    lowpow_next = low_power_latch && !s1_tick.adaptor_present;
    may_start   = (s1_tick.bat1_has_runtime || s1_tick.bat2_has_runtime) && !lowpow_next;

    // Off: switch and lid edges may start the board.
    if (mode_next == MODE_OFF) begin
      if (!button_next && sw) begin
        if (may_start) mode_next = MODE_RUN;
        button_next = 1'b1;
      end else if (button_next && !sw) begin
        button_next = 1'b0;
      end
      if (!cover_next && !covered) begin
        if (may_start) mode_next = button_next ? MODE_RUN : MODE_FAST;
        cover_next = 1'b1;
      end else if (cover_next && covered) begin
        cover_next = 1'b0;
      end
    end

    // Run: low voltage, lid timeout and switch release turn the board off.
    if (mode_next == MODE_RUN) begin
      if (!volt_low) begin
        since_next = 32'd0;
      end else if (low_volt_since == 32'd0) begin
        since_next = s1_tick.now_seconds;
      end else if (lv_trip) begin
        mode_next   = MODE_OFF;
        lowpow_next = 1'b1;
      end
      if (cover_next && covered) cover_next = 1'b0;
      if (!cover_next && lid_cover_late) mode_next = MODE_OFF;
      if (button_next && !sw) begin
        mode_next   = MODE_OFF;
        button_next = 1'b0;
      end
    end

    // Fast boot: lid timeout, switch press, lid close, then low voltage.
    if (mode_next == MODE_FAST) begin
      if (lid_uncover_late) mode_next = MODE_OFF;
      if (!button_next && sw && !lowpow_next) begin
        mode_next   = MODE_RUN;
        button_next = 1'b1;
      end
      if (cover_next && covered) begin
        mode_next  = MODE_OFF;
        cover_next = 1'b0;
      end
      if (!volt_low) begin
        since_next = 32'd0;
      end else if (low_volt_since == 32'd0) begin
        since_next = s1_tick.now_seconds;
      end else if (lv_trip) begin
        mode_next   = MODE_OFF;
        lowpow_next = 1'b1;
      end
    end
  end

  // Tick register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
    if (tick.valid && tick.ready) begin
      s1_tick <= tick.payload;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_OFF;
      button_latch    <= 1'b0;
      cover_latch     <= 1'b0;
      low_volt_since  <= 32'd0;
      low_power_latch <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_reg        <= mode_next;
        button_latch    <= button_next;
        cover_latch     <= cover_next;
        low_volt_since  <= since_next;
        low_power_latch <= lowpow_next;
        out_valid       <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_result.power_mode        <= mode_next;
      out_result.main_board_enable <= (mode_next == MODE_RUN) || (mode_next == MODE_FAST);
      out_result.aux_board_enable  <= mode_next == MODE_RUN;
      out_result.fan_enable        <= mode_next == MODE_RUN;
      out_result.low_power_latched <= lowpow_next;
    end
  end

  // A held tick that cannot move on keeps its contents.
  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_tick))
    else $error("tick register changed while stalled");

  // The mode register never takes the unused code.
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == MODE_OFF) || (mode_reg == MODE_RUN) || (mode_reg == MODE_FAST))
    else $error("mode register holds an unused code");

  // A low-voltage shutdown always leaves the board off.
  a_lowpow_off: assert property (@(posedge clk) disable iff (rst)
    $rose(low_power_latch) |-> mode_reg == MODE_OFF)
    else $error("low-power latch set while board powered");

  // The second board and fan never run without the main board.
  a_enable_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.aux_board_enable || out_result.fan_enable)
      |-> out_result.main_board_enable)
    else $error("aux or fan enabled without main board");

  // The result register mirrors the state it was loaded from.
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid && out_result.power_mode == mode_reg &&
               out_result.low_power_latched == low_power_latch)
    else $error("result does not match sequencer state");

endmodule

// ===== verif/lps_mode_checker.sv =====
// Result checker for the load power sequencer: watches the tick, result and register ports.
// Predicts each result from its own copy of the sequencer state and compares it field by field.
// Depends on lps_pkg for the tick and result structs, mode codes and register indexes.
module lps_mode_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  input  logic                             tick_ready,
  input  lps_pkg::lps_tick_t               tick_payload,
  input  logic                             result_valid,
  input  logic                             result_ready,
  input  lps_pkg::lps_result_t             result_payload,
  input  logic                             cfg_we,
  input  logic [lps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               pending,
  output int                               mismatches
);
  import lps_pkg::*;

  // Predicted register settings.
  logic [13:0] thr_mv;
  logic [7:0]  hold_s;
  logic [15:0] tmo_s;

  // Predicted sequencer state.
  logic [1:0]  mode;
  logic        btn_latch;
  logic        lid_latch;
  logic        lp_latch;
  logic [31:0] low_since;

  // Results still owed by the block, oldest first.
  lps_result_t owed_results[$];

  initial begin
    pending = 0;
    mismatches = 0;
  end

  task automatic note_failure(input string msg);
    if (mismatches < 10) begin
      $display("%s", msg);
    end
    mismatches++;
  endtask

  // Low-voltage timing: a stamp of zero means the timer is not running.
  task automatic track_low_voltage(input logic [31:0] now, input logic [13:0] volt);
    if (volt <= thr_mv) begin
      if (low_since == 32'd0) begin
        low_since = now;
      end else if (32'(now - low_since) >= 32'(hold_s)) begin
        mode = MODE_OFF;
        lp_latch = 1'b1;
      end
    end else begin
      low_since = 32'd0;
    end
  endtask

  // One control tick: off, run and fast-boot checks in that order.
  task automatic step_sequencer(input lps_tick_t t, output lps_result_t r);
    logic        may_start;
    logic [31:0] now;
    now = t.now_seconds;
    if (t.adaptor_present) begin
      lp_latch = 1'b0;
    end

    if (mode == MODE_OFF) begin
      may_start = (t.bat1_has_runtime | t.bat2_has_runtime) && !lp_latch;
      if (!btn_latch && t.switch_on) begin
        if (may_start) begin
          mode = MODE_RUN;
        end
        btn_latch = 1'b1;
      end else if (btn_latch && !t.switch_on) begin
        btn_latch = 1'b0;
      end
      if (!lid_latch && !t.lid_covered) begin
        if (may_start) begin
          mode = btn_latch ? MODE_RUN : MODE_FAST;
        end
        lid_latch = 1'b1;
      end else if (lid_latch && t.lid_covered) begin
        lid_latch = 1'b0;
      end
    end

    if (mode == MODE_RUN) begin
      track_low_voltage(now, t.sys_voltage_mv);
      if (lid_latch && t.lid_covered) begin
        lid_latch = 1'b0;
      end
      // With the cover latch clear the timeout runs from the cover stamp.
      if (!lid_latch && 32'(now - t.lid_cover_stamp) >= 32'(tmo_s)) begin
        mode = MODE_OFF;
      end
      if (btn_latch && !t.switch_on) begin
        mode = MODE_OFF;
        btn_latch = 1'b0;
      end
    end

    if (mode == MODE_FAST) begin
      if (32'(now - t.lid_uncover_stamp) >= 32'(tmo_s)) begin
        mode = MODE_OFF;
      end
      if (!btn_latch && t.switch_on && !lp_latch) begin
        mode = MODE_RUN;
        btn_latch = 1'b1;
      end
      if (lid_latch && t.lid_covered) begin
        mode = MODE_OFF;
        lid_latch = 1'b0;
      end
      track_low_voltage(now, t.sys_voltage_mv);
    end

    r.power_mode        = mode;
    r.main_board_enable = (mode == MODE_RUN) || (mode == MODE_FAST);
    r.aux_board_enable  = (mode == MODE_RUN);
    r.fan_enable        = (mode == MODE_RUN);
    r.low_power_latched = lp_latch;
  endtask

  // Sample all ports at the clock edge: compare results first, then predict new requests.
  always @(posedge clk) begin : monitor
    lps_result_t want;
    if (rst) begin
      thr_mv    = STOP_THRESHOLD_RESET;
      hold_s    = LOW_VOLT_HOLD_RESET;
      tmo_s     = LID_TIMEOUT_RESET;
      mode      = MODE_OFF;
      btn_latch = 1'b0;
      lid_latch = 1'b0;
      lp_latch  = 1'b0;
      low_since = 32'd0;
      owed_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("lps_checker: result with nothing expected, got %h",
                                 result_payload));
        end else begin
          want = owed_results.pop_front();
          if (result_payload.power_mode !== want.power_mode ||
              result_payload.main_board_enable !== want.main_board_enable ||
              result_payload.aux_board_enable !== want.aux_board_enable ||
              result_payload.fan_enable !== want.fan_enable ||
              result_payload.low_power_latched !== want.low_power_latched) begin
            note_failure($sformatf({
              "lps_checker: expected mode=%0d main=%b aux=%b fan=%b lp=%b, ",
              "got mode=%0d main=%b aux=%b fan=%b lp=%b"},
              want.power_mode, want.main_board_enable, want.aux_board_enable,
              want.fan_enable, want.low_power_latched,
              result_payload.power_mode, result_payload.main_board_enable,
              result_payload.aux_board_enable, result_payload.fan_enable,
              result_payload.low_power_latched));
          end
        end
      end
      if (tick_valid && tick_ready) begin
        step_sequencer(tick_payload, want);
        owed_results.push_back(want);
      end
      // Register writes keep only each register's width; other indexes are ignored.
      if (cfg_we) begin
        case (cfg_index)
          CFG_STOP_THRESHOLD: thr_mv = cfg_data[13:0];
          CFG_LOW_VOLT_HOLD:  hold_s = cfg_data[7:0];
          CFG_LID_TIMEOUT:    tmo_s  = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top of the load power sequencer testbench: clock, reset, request stimulus and verdict.
// Depends on lps_pkg, lps_stream_if, load_power_sequencer and lps_mode_checker.
module tb;
  import lps_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_TICKS = 245;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic idle_enable;
  int   pending;
  int   mismatches;
  int   stall_cycles;

  // Scenario state for well-formed tick sequences.
  logic [31:0] sim_now;
  logic [31:0] cover_at;
  logic [31:0] uncover_at;
  logic        sw_lvl;
  logic        lid_lvl;
  logic        adp_lvl;
  int          low_left;
  logic [13:0] cur_thr;

  lps_stream_if #(.payload_t(lps_tick_t))   tick_ch ();
  lps_stream_if #(.payload_t(lps_result_t)) result_ch ();

  load_power_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lps_mode_checker mode_check (
    .clk            (clk),
    .rst            (rst),
    .tick_valid     (tick_ch.valid),
    .tick_ready     (tick_ch.ready),
    .tick_payload   (tick_ch.payload),
    .result_valid   (result_ch.valid),
    .result_ready   (result_ch.ready),
    .result_payload (result_ch.payload),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .mismatches     (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side stalls at random, about 15 percent of the time, while idling is enabled.
  always @(posedge clk) begin
    if (idle_enable && $urandom_range(99) < 15) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_tick(input lps_tick_t t);
    while (idle_enable && $urandom_range(99) < 15) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.payload <= t;
    @(posedge clk);
    while (!tick_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [31:0] now, input logic sw, input logic cov,
                             input logic adp, input logic [13:0] volt, input logic b1,
                             input logic b2, input logic [31:0] cst, input logic [31:0] ust);
    lps_tick_t t;
    t.now_seconds       = now;
    t.switch_on         = sw;
    t.lid_covered       = cov;
    t.adaptor_present   = adp;
    t.sys_voltage_mv    = volt;
    t.bat1_has_runtime  = b1;
    t.bat2_has_runtime  = b2;
    t.lid_cover_stamp   = cst;
    t.lid_uncover_stamp = ust;
    send_tick(t);
  endtask

  // Hold off requests until every expected result has come back.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges, optionally poking the unused index.
  task automatic program_regs(input logic [15:0] thr, input logic [15:0] hold,
                              input logic [15:0] tmo, input logic poke_unused);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    int                     count;
    idx[0] = CFG_STOP_THRESHOLD; val[0] = thr;
    idx[1] = CFG_LOW_VOLT_HOLD;  val[1] = hold;
    idx[2] = CFG_LID_TIMEOUT;    val[2] = tmo;
    idx[3] = CFG_UNUSED;         val[3] = 16'h5A3C;
    count = poke_unused ? 4 : 3;
    for (int i = 0; i < count; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_thr = thr[13:0];
  endtask

  // Next tick of a plausible session, or pure noise now and then.
  task automatic next_tick(output lps_tick_t t);
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      sim_now = sim_now + 32'd1;
    end else if (pick < 82) begin
      // Same second again.
    end else if (pick < 97) begin
      sim_now = sim_now + 32'($urandom_range(2, 25));
    end else if ($urandom_range(1) == 1) begin
      sim_now = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    end else begin
      sim_now = $urandom;
    end

    if ($urandom_range(99) < 8) begin
      sw_lvl = !sw_lvl;
    end
    if ($urandom_range(99) < 6) begin
      lid_lvl = !lid_lvl;
      if (lid_lvl) begin
        cover_at = sim_now;
      end else begin
        uncover_at = sim_now;
      end
    end
    if ($urandom_range(99) < 5) begin
      adp_lvl = !adp_lvl;
    end
    if (low_left > 0) begin
      low_left--;
    end else if ($urandom_range(99) < 5) begin
      low_left = $urandom_range(1, 15);
    end

    t.now_seconds       = sim_now;
    t.switch_on         = sw_lvl;
    t.lid_covered       = lid_lvl;
    t.adaptor_present   = adp_lvl;
    t.bat1_has_runtime  = ($urandom_range(99) < 70);
    t.bat2_has_runtime  = ($urandom_range(99) < 50);
    t.lid_cover_stamp   = cover_at;
    t.lid_uncover_stamp = uncover_at;
    if (low_left > 0) begin
      t.sys_voltage_mv = 14'($urandom_range(0, cur_thr));
    end else if (cur_thr == 14'h3FFF) begin
      t.sys_voltage_mv = 14'($urandom_range(0, 16383));
    end else begin
      t.sys_voltage_mv = 14'($urandom_range(cur_thr + 1, 16383));
    end
    // A stale or bogus stamp now and then.
    if ($urandom_range(99) < 5) begin
      t.lid_cover_stamp = $urandom;
    end
    if ($urandom_range(99) < 5) begin
      t.lid_uncover_stamp = $urandom;
    end

    // Noise: every field drawn at random.
    if ($urandom_range(99) < 12) begin
      t.now_seconds       = $urandom;
      t.switch_on         = 1'($urandom);
      t.lid_covered       = 1'($urandom);
      t.adaptor_present   = 1'($urandom);
      t.sys_voltage_mv    = 14'($urandom);
      t.bat1_has_runtime  = 1'($urandom);
      t.bat2_has_runtime  = 1'($urandom);
      t.lid_cover_stamp   = $urandom;
      t.lid_uncover_stamp = $urandom;
    end
  endtask

  initial begin : stimulus
    lps_tick_t t;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    idle_enable     = 1'b1;
    tick_ch.valid   = 1'b0;
    tick_ch.payload = '0;
    sim_now         = 32'd1000;
    cover_at        = 32'd1000;
    uncover_at      = 32'd1000;
    sw_lvl          = 1'b0;
    lid_lvl         = 1'b1;
    adp_lvl         = 1'b0;
    low_left        = 0;
    cur_thr         = STOP_THRESHOLD_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed session with the register defaults.
    // Switch press, but a cover stamp just below the wrap point ends run by lid timeout.
    send_fields(32'd100, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b1, 32'd100, 32'd100);
    send_fields(32'd101, 1'b1, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b1, 32'hFFFF_FF00, 32'd100);
    // Low voltage first seen at second zero does not start the timer.
    send_fields(32'd0, 1'b1, 1'b1, 1'b0, 14'd8000, 1'b1, 1'b1, 32'hFFFF_FF00, 32'd100);
    send_fields(32'd1, 1'b1, 1'b1, 1'b0, 14'd8000, 1'b1, 1'b1, 32'hFFFF_FF00, 32'd100);
    // Voltage exactly at the threshold while the board is off latches nothing.
    send_fields(32'd8, 1'b1, 1'b1, 1'b0, 14'd9000, 1'b1, 1'b1, 32'hFFFF_FF00, 32'd100);
    send_fields(32'd9, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b1, 32'd9, 32'd9);
    // With no low power latched, switch presses restart run mode and a release turns it off.
    send_fields(32'd10, 1'b1, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b1, 32'd10, 32'd10);
    send_fields(32'd11, 1'b0, 1'b1, 1'b1, 14'd12000, 1'b1, 1'b1, 32'd11, 32'd11);
    send_fields(32'd12, 1'b1, 1'b1, 1'b0, 14'd16383, 1'b1, 1'b1, 32'd12, 32'd12);
    // Run mode lid timeout measured from the cover stamp.
    send_fields(32'd400, 1'b1, 1'b1, 1'b0, 14'd16383, 1'b1, 1'b1, 32'd100, 32'd12);
    send_fields(32'd401, 1'b0, 1'b1, 1'b0, 14'd16383, 1'b1, 1'b1, 32'd100, 32'd12);
    // Opening the lid with only battery two gives fast boot; the switch then gives run.
    send_fields(32'd402, 1'b0, 1'b0, 1'b0, 14'd12000, 1'b0, 1'b1, 32'd100, 32'd402);
    send_fields(32'd403, 1'b1, 1'b0, 1'b0, 14'd12000, 1'b0, 1'b1, 32'd100, 32'd402);
    send_fields(32'd404, 1'b1, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd404, 32'd402);
    send_fields(32'd405, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd404, 32'd402);
    // Fast boot lid timeout measured from the uncover stamp.
    send_fields(32'd406, 1'b0, 1'b0, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd404, 32'd406);
    send_fields(32'd706, 1'b0, 1'b0, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd404, 32'd406);
    send_fields(32'd707, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd707, 32'd406);
    // No battery runtime: the lid opens but nothing starts.
    send_fields(32'd708, 1'b0, 1'b0, 1'b0, 14'd12000, 1'b0, 1'b0, 32'd707, 32'd708);
    send_fields(32'd709, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b0, 1'b0, 32'd709, 32'd708);
    // Fast boot ended by closing the lid.
    send_fields(32'd710, 1'b0, 1'b0, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd709, 32'd710);
    send_fields(32'd711, 1'b0, 1'b1, 1'b0, 14'd12000, 1'b1, 1'b0, 32'd711, 32'd710);
    // Field extremes across the seconds wrap, with zero volts.
    send_fields(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 14'd0, 1'b1, 1'b0,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(32'd0, 1'b1, 1'b1, 1'b0, 14'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
    send_fields(32'd20, 1'b1, 1'b1, 1'b0, 14'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0);

    // Random sessions, each behind a drained pipe and a fresh register setting.
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: program_regs(16'hFFFF, 16'hFF00, 16'h0000, 1'b1);
        1: program_regs(16'h0000, 16'h00FF, 16'hFFFF, 1'b0);
        default: program_regs(16'($urandom_range(6000, 12000)), 16'($urandom_range(1, 12)),
                              16'($urandom_range(3, 40)), 1'b0);
      endcase
      idle_enable <= (ph != 3);
      repeat (PHASE_TICKS) begin
        next_tick(t);
        send_tick(t);
      end
    end

    // Drain, let the pipe settle, then give the verdict.
    tick_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
